/* rtl/pclb_pkg.sv */
package pclb_pkg;

  // Table geometry
  localparam int MAX_CELLS     = 4096;
  localparam int MAX_SLOTS     = 16;
  localparam int MAX_PARTICLES = 65536;

  localparam int CELL_W = $clog2(MAX_CELLS);
  localparam int SLOT_W = $clog2(MAX_SLOTS);
  localparam int PART_W = $clog2(MAX_PARTICLES);
  localparam int PCNT_W = PART_W + 1;
  localparam int CNT_W  = 5;
  localparam int SADDR_W = CELL_W + SLOT_W;

  // Grid axis limits
  localparam int AXIS_MAX = 64;
  localparam int AXIS_W   = 7;
  localparam int BIN_W    = $clog2(AXIS_MAX);

  // Register widths and reset values
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 2;
  localparam logic [31:0]       RST_INV_CELL_SIZE = 32'd65536;
  localparam logic [AXIS_W-1:0] RST_CELLS         = AXIS_W'(64);
  localparam logic [CNT_W-1:0]  RST_SLOTS         = CNT_W'(8);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PLACE = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_INV_CELL_SIZE  = 2'd0,
    REG_CELLS_X        = 2'd1,
    REG_CELLS_Y        = 2'd2,
    REG_SLOTS_PER_CELL = 2'd3
  } reg_e;

  typedef struct packed {
    logic [31:0]       inv_cell_size;
    logic [AXIS_W-1:0] cells_x;
    logic [AXIS_W-1:0] cells_y;
    logic [CNT_W-1:0]  slots_per_cell;
  } cfg_t;

  typedef struct packed {
    cmd_e              cmd;
    logic [CELL_W-1:0] cell_no;
    logic [SLOT_W-1:0] ssel;
  } q_ent_t;

  typedef struct packed {
    logic [CELL_W-1:0] cell_index;
    logic [CNT_W-1:0]  slot;
    logic [PART_W-1:0] particle_index;
    logic [CNT_W-1:0]  cell_count;
    logic              overflow;
    logic [CNT_W-1:0]  needed_capacity;
  } res_t;

  // Map a raw axis register onto 1..AXIS_MAX
  function automatic logic [AXIS_W-1:0] axis_cells(input logic [AXIS_W-1:0] r);
    logic [AXIS_W-1:0] v;
    if (r == '0) begin
      v = AXIS_W'(1);
    end else if (r > AXIS_W'(AXIS_MAX)) begin
      v = AXIS_W'(AXIS_MAX);
    end else begin
      v = r;
    end
    return v;
  endfunction

endpackage

/* rtl/pclb_queue.sv */
module pclb_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pclb_pkg::q_ent_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output pclb_pkg::q_ent_t head_o,
  output logic            empty_o
);

  pclb_pkg::q_ent_t ents_q [pclb_pkg::QUEUE_DEPTH];
  logic [pclb_pkg::QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [pclb_pkg::QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [pclb_pkg::QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == pclb_pkg::QCNT_W'(pclb_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign head_o  = ents_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pclb_pkg::QPTR_W'(pclb_pkg::QUEUE_DEPTH - 1)) ? '0
               : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pclb_pkg::QPTR_W'(pclb_pkg::QUEUE_DEPTH - 1)) ? '0
               : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ents_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

/* rtl/pclb_front.sv */
module pclb_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pclb_pkg::cfg_t                cfg_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    command_i,
  input  logic [31:0]                   pos_x_i,
  input  logic [31:0]                   pos_y_i,
  input  logic [pclb_pkg::CELL_W-1:0]   cell_select_i,
  input  logic [pclb_pkg::SLOT_W-1:0]   slot_select_i,
  input  logic                          sweep_i,
  output logic                          push_o,
  output pclb_pkg::q_ent_t              entry_o,
  input  logic                          full_i
);

  logic                                s1_vld_q, s1_vld_d;
  pclb_pkg::cmd_e                      s1_cmd_q;
  logic [31:0]                         s1_x_q, s1_y_q;
  logic [pclb_pkg::CELL_W-1:0]         s1_csel_q;
  logic [pclb_pkg::SLOT_W-1:0]         s1_ssel_q;
  logic                                accept;
  logic [63:0]                         prod_x, prod_y;
  logic [pclb_pkg::AXIS_W-1:0]         cx, cy;
  logic [pclb_pkg::BIN_W-1:0]          cx_last, cy_last, bx, by;
  logic [pclb_pkg::CELL_W:0]           byx, cell_sum;
  logic [pclb_pkg::CELL_W-1:0]         place_cell;

  assign in_stall_o = sweep_i || (s1_vld_q && full_i);
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = s1_vld_q && !full_i;
  assign s1_vld_d   = accept || (s1_vld_q && !push_o);

  // Scale by the reciprocal cell size; the integer bin is the upper word
  assign prod_x = pos_x_i * cfg_i.inv_cell_size;
  assign prod_y = pos_y_i * cfg_i.inv_cell_size;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= s1_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_cmd_q  <= pclb_pkg::cmd_e'(command_i);
      s1_x_q    <= prod_x[63:32];
      s1_y_q    <= prod_y[63:32];
      s1_csel_q <= cell_select_i;
      s1_ssel_q <= slot_select_i;
    end
  end

  // Clamp each axis into the grid, then form the row-major cell number
  assign cx      = pclb_pkg::axis_cells(cfg_i.cells_x);
  assign cy      = pclb_pkg::axis_cells(cfg_i.cells_y);
  assign cx_last = pclb_pkg::BIN_W'(cx - 1'b1);
  assign cy_last = pclb_pkg::BIN_W'(cy - 1'b1);
  assign bx = (s1_x_q > 32'(cx_last)) ? cx_last : s1_x_q[pclb_pkg::BIN_W-1:0];
  assign by = (s1_y_q > 32'(cy_last)) ? cy_last : s1_y_q[pclb_pkg::BIN_W-1:0];
  assign byx      = (pclb_pkg::CELL_W+1)'(by) * (pclb_pkg::CELL_W+1)'(cx);
  assign cell_sum = byx + (pclb_pkg::CELL_W+1)'(bx);
  assign place_cell = (cell_sum >= (pclb_pkg::CELL_W+1)'(pclb_pkg::MAX_CELLS))
                    ? pclb_pkg::CELL_W'(pclb_pkg::MAX_CELLS - 1)
                    : cell_sum[pclb_pkg::CELL_W-1:0];

  always_comb begin
    entry_o.cmd     = s1_cmd_q;
    entry_o.cell_no = (s1_cmd_q == pclb_pkg::CMD_READ) ? s1_csel_q : place_cell;
    entry_o.ssel    = s1_ssel_q;
  end

endmodule

/* rtl/pclb_back.sv */
module pclb_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pclb_pkg::cfg_t   cfg_i,
  input  pclb_pkg::q_ent_t head_i,
  input  logic             empty_i,
  output logic             pop_o,
  output logic             sweep_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output pclb_pkg::res_t   res_o
);

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_EXEC
  } state_e;

  localparam logic [pclb_pkg::CNT_W-1:0] CNT_MAX = '1;

  state_e                              state_q, state_d;
  pclb_pkg::q_ent_t                    op_q, op_d;
  logic [pclb_pkg::CELL_W-1:0]         sweep_q, sweep_d;
  logic [pclb_pkg::PCNT_W-1:0]         pcnt_q, pcnt_d;
  logic                                ovf_q, ovf_d;
  logic [pclb_pkg::CNT_W-1:0]          need_q, need_d;
  logic                                out_vld_q, out_vld_d;
  pclb_pkg::res_t                      res_q, res_d;
  logic                                fwd_cnt_vld_q, fwd_cnt_vld_d;
  logic [pclb_pkg::CNT_W-1:0]          fwd_cnt_q, fwd_cnt_d;
  logic                                fwd_slot_vld_q, fwd_slot_vld_d;
  logic [pclb_pkg::PART_W-1:0]         fwd_slot_q, fwd_slot_d;

  logic [pclb_pkg::CNT_W-1:0]          cnt_mem [pclb_pkg::MAX_CELLS];
  logic [pclb_pkg::PART_W-1:0]         slot_mem [pclb_pkg::MAX_CELLS * pclb_pkg::MAX_SLOTS];
  logic [pclb_pkg::CNT_W-1:0]          cnt_rd_q;
  logic [pclb_pkg::PART_W-1:0]         slot_rd_q;

  logic                                cnt_we, slot_we;
  logic [pclb_pkg::CELL_W-1:0]         cnt_waddr;
  logic [pclb_pkg::CNT_W-1:0]          cnt_wdata;
  logic [pclb_pkg::SADDR_W-1:0]        slot_waddr, head_saddr;
  logic [pclb_pkg::PART_W-1:0]         slot_wdata;

  logic                                out_free, place_ok, fits, slot_wr;
  logic [pclb_pkg::CNT_W-1:0]          spc, cur_cnt, new_cnt;
  logic [pclb_pkg::PART_W-1:0]         cur_sdata;

  assign sweep_o     = (state_q == ST_SWEEP);
  assign out_valid_o = out_vld_q;
  assign res_o       = res_q;
  assign out_free    = !out_vld_q || !out_stall_i;
  assign head_saddr  = {head_i.cell_no, head_i.ssel};

  // Effective capacity, 1..MAX_SLOTS
  assign spc = (cfg_i.slots_per_cell == '0) ? pclb_pkg::CNT_W'(1)
             : (cfg_i.slots_per_cell > pclb_pkg::CNT_W'(pclb_pkg::MAX_SLOTS))
               ? pclb_pkg::CNT_W'(pclb_pkg::MAX_SLOTS) : cfg_i.slots_per_cell;

  // Take the value just written when the previous item hit the same entry
  assign cur_cnt   = fwd_cnt_vld_q ? fwd_cnt_q : cnt_rd_q;
  assign cur_sdata = fwd_slot_vld_q ? fwd_slot_q : slot_rd_q;

  assign place_ok = (op_q.cmd == pclb_pkg::CMD_PLACE) && !ovf_q &&
                    (pcnt_q < pclb_pkg::PCNT_W'(pclb_pkg::MAX_PARTICLES));
  assign fits     = (cur_cnt < spc);
  assign new_cnt  = (cur_cnt != CNT_MAX) ? pclb_pkg::CNT_W'(cur_cnt + 1'b1) : cur_cnt;
  assign slot_wr  = place_ok && (cur_cnt < pclb_pkg::CNT_W'(pclb_pkg::MAX_SLOTS));

  always_comb begin
    state_d        = state_q;
    op_d           = op_q;
    sweep_d        = sweep_q;
    pcnt_d         = pcnt_q;
    ovf_d          = ovf_q;
    need_d         = need_q;
    res_d          = res_q;
    out_vld_d      = out_vld_q && out_stall_i;
    fwd_cnt_vld_d  = fwd_cnt_vld_q;
    fwd_cnt_d      = fwd_cnt_q;
    fwd_slot_vld_d = fwd_slot_vld_q;
    fwd_slot_d     = fwd_slot_q;
    pop_o          = 1'b0;
    cnt_we         = 1'b0;
    cnt_waddr      = sweep_q;
    cnt_wdata      = '0;
    slot_we        = 1'b0;
    slot_waddr     = {op_q.cell_no, cur_cnt[pclb_pkg::SLOT_W-1:0]};
    slot_wdata     = fits ? pcnt_q[pclb_pkg::PART_W-1:0] : '0;

    unique case (state_q)
      ST_SWEEP: begin
        cnt_we  = 1'b1;
        sweep_d = sweep_q + 1'b1;
        if (sweep_q == pclb_pkg::CELL_W'(pclb_pkg::MAX_CELLS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (!empty_i) begin
          pop_o          = 1'b1;
          op_d           = head_i;
          fwd_cnt_vld_d  = 1'b0;
          fwd_slot_vld_d = 1'b0;
          state_d        = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          out_vld_d = 1'b1;
          res_d     = '0;
          unique case (op_q.cmd)
            pclb_pkg::CMD_CLEAR: begin
              pcnt_d = '0;
              ovf_d  = 1'b0;
              need_d = '0;
            end
            pclb_pkg::CMD_PLACE: begin
              if (place_ok) begin
                cnt_we                 = 1'b1;
                cnt_waddr              = op_q.cell_no;
                cnt_wdata              = new_cnt;
                slot_we                = slot_wr;
                res_d.cell_index       = op_q.cell_no;
                res_d.slot             = fits ? cur_cnt : '0;
                res_d.particle_index   = pcnt_q[pclb_pkg::PART_W-1:0];
                res_d.cell_count       = new_cnt;
                if (fits) begin
                  pcnt_d = pcnt_q + 1'b1;
                end else begin
                  ovf_d  = 1'b1;
                  need_d = pclb_pkg::CNT_W'(cur_cnt + 1'b1);
                end
              end
            end
            pclb_pkg::CMD_READ: begin
              res_d.cell_index = op_q.cell_no;
              res_d.slot       = pclb_pkg::CNT_W'(op_q.ssel);
              res_d.cell_count = cur_cnt;
              if (pclb_pkg::CNT_W'(op_q.ssel) < cur_cnt) begin
                res_d.particle_index = cur_sdata;
              end
            end
            default: begin
            end
          endcase
          res_d.overflow        = ovf_d;
          res_d.needed_capacity = need_d;

          if (op_q.cmd == pclb_pkg::CMD_CLEAR) begin
            sweep_d = '0;
            state_d = ST_SWEEP;
          end else if (!empty_i) begin
            // Issue the next item's reads alongside this item's writes
            pop_o          = 1'b1;
            op_d           = head_i;
            fwd_cnt_vld_d  = place_ok && (head_i.cell_no == op_q.cell_no);
            fwd_cnt_d      = new_cnt;
            fwd_slot_vld_d = slot_wr && (head_i.cmd == pclb_pkg::CMD_READ) &&
                             (head_saddr == slot_waddr);
            fwd_slot_d     = slot_wdata;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_SWEEP;
      sweep_q        <= '0;
      pcnt_q         <= '0;
      ovf_q          <= 1'b0;
      need_q         <= '0;
      out_vld_q      <= 1'b0;
      fwd_cnt_vld_q  <= 1'b0;
      fwd_slot_vld_q <= 1'b0;
      op_q           <= '0;
      res_q          <= '0;
      fwd_cnt_q      <= '0;
      fwd_slot_q     <= '0;
    end else begin
      state_q        <= state_d;
      sweep_q        <= sweep_d;
      pcnt_q         <= pcnt_d;
      ovf_q          <= ovf_d;
      need_q         <= need_d;
      out_vld_q      <= out_vld_d;
      fwd_cnt_vld_q  <= fwd_cnt_vld_d;
      fwd_slot_vld_q <= fwd_slot_vld_d;
      op_q           <= op_d;
      res_q          <= res_d;
      fwd_cnt_q      <= fwd_cnt_d;
      fwd_slot_q     <= fwd_slot_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cnt_we) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (pop_o) begin
      cnt_rd_q <= cnt_mem[head_i.cell_no];
    end
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    if (pop_o) begin
      slot_rd_q <= slot_mem[head_saddr];
    end
  end

endmodule

/* rtl/particle_cell_list_binner.sv */
// Bins 2D particles into a row-major grid of cells_x by cells_y cells with
// slots_per_cell slots each. A place scales pos_x/pos_y (Q16.16) by
// inv_cell_size, floors and clamps each axis, stores the next particle number
// in the cell's next free slot and returns cell and slot; a place into a full
// cell sets the sticky overflow flag with the capacity that would have fit,
// and later places return zeros but for the overflow fields until the next
// clear. A read returns one cell's count and one slot. The front end takes
// one beat per cycle unless stalled, registers the upper words of the two
// 32x32 scale products and queues the item; the back end issues the count and
// slot memory reads as it pops the item and completes the read-modify-write
// in its execute state, overlapping the next item's reads with the current
// writes (same-cell hits are forwarded), so a steady stream of place and read
// beats moves at one per cycle while the result port is not stalled. A clear
// returns its result and then sweeps the 4096-entry count memory, one entry
// per cycle; the same sweep runs after reset. The input stalls during a sweep.
// Configuration registers are written through cfg_we_i/cfg_idx_i/cfg_data_i
// and must only change while the block is idle.
module particle_cell_list_binner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Configuration write port
  input  logic                              cfg_we_i,
  input  logic [pclb_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pclb_pkg::CFG_W-1:0]        cfg_data_i,
  // Input beats
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [1:0]                        command_i,
  input  logic [31:0]                       pos_x_i,
  input  logic [31:0]                       pos_y_i,
  input  logic [pclb_pkg::CELL_W-1:0]       cell_select_i,
  input  logic [pclb_pkg::SLOT_W-1:0]       slot_select_i,
  // Result beats
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pclb_pkg::CELL_W-1:0]       cell_index_o,
  output logic [pclb_pkg::CNT_W-1:0]        slot_o,
  output logic [pclb_pkg::PART_W-1:0]       particle_index_o,
  output logic [pclb_pkg::CNT_W-1:0]        cell_count_o,
  output logic                              overflow_o,
  output logic [pclb_pkg::CNT_W-1:0]        needed_capacity_o
);

  pclb_pkg::cfg_t   cfg_q;
  pclb_pkg::q_ent_t push_ent, head_ent;
  pclb_pkg::res_t   res;
  logic             push, pop, full, empty, sweep;

  // Hold the configuration registers; write them only while idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.inv_cell_size  <= pclb_pkg::RST_INV_CELL_SIZE;
      cfg_q.cells_x        <= pclb_pkg::RST_CELLS;
      cfg_q.cells_y        <= pclb_pkg::RST_CELLS;
      cfg_q.slots_per_cell <= pclb_pkg::RST_SLOTS;
    end else if (cfg_we_i) begin
      unique case (pclb_pkg::reg_e'(cfg_idx_i))
        pclb_pkg::REG_INV_CELL_SIZE:  cfg_q.inv_cell_size  <= cfg_data_i;
        pclb_pkg::REG_CELLS_X:        cfg_q.cells_x        <= cfg_data_i[pclb_pkg::AXIS_W-1:0];
        pclb_pkg::REG_CELLS_Y:        cfg_q.cells_y        <= cfg_data_i[pclb_pkg::AXIS_W-1:0];
        pclb_pkg::REG_SLOTS_PER_CELL: cfg_q.slots_per_cell <= cfg_data_i[pclb_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: accept, scale and classify each beat into a queue entry
  pclb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .pos_x_i       (pos_x_i),
    .pos_y_i       (pos_y_i),
    .cell_select_i (cell_select_i),
    .slot_select_i (slot_select_i),
    .sweep_i       (sweep),
    .push_o        (push),
    .entry_o       (push_ent),
    .full_i        (full)
  );

  // Short queue decouples the multiplier front from the memory back
  pclb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_ent),
    .full_o  (full),
    .pop_i   (pop),
    .head_o  (head_ent),
    .empty_o (empty)
  );

  // Back: count/slot memories, overflow state, result register
  pclb_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .head_i      (head_ent),
    .empty_i     (empty),
    .pop_o       (pop),
    .sweep_o     (sweep),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign cell_index_o      = res.cell_index;
  assign slot_o            = res.slot;
  assign particle_index_o  = res.particle_index;
  assign cell_count_o      = res.cell_count;
  assign overflow_o        = res.overflow;
  assign needed_capacity_o = res.needed_capacity;

endmodule

/* rtl/pclb_checker.sv */
module pclb_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [pclb_pkg::CELL_W-1:0]     cell_index_o,
  input logic [pclb_pkg::CNT_W-1:0]      slot_o,
  input logic [pclb_pkg::PART_W-1:0]     particle_index_o,
  input logic [pclb_pkg::CNT_W-1:0]      cell_count_o,
  input logic                            overflow_o,
  input logic [pclb_pkg::CNT_W-1:0]      needed_capacity_o
);

  // Hold a stalled result beat
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(cell_index_o) &&
      $stable(slot_o) && $stable(particle_index_o) && $stable(cell_count_o) &&
      $stable(overflow_o) && $stable(needed_capacity_o))
    else $error("stalled result beat changed");

  // Count memory sweep runs right after reset
  a_reset_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input not stalled during post-reset sweep");

  // Needed capacity is nonzero exactly when overflow is flagged
  a_need_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (overflow_o == (needed_capacity_o != '0)))
    else $error("needed_capacity and overflow disagree");

  // A nonzero particle number always comes from an occupied cell
  a_part_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (particle_index_o != '0) |-> (cell_count_o != '0))
    else $error("particle reported from empty cell");

endmodule

bind particle_cell_list_binner pclb_checker u_pclb_checker (.*);

/* tb/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pclb_pkg::*;

  // One beat on the input channel, as the generator queues it.
  typedef struct packed {
    cmd_e              cmd;
    logic [31:0]       px;
    logic [31:0]       py;
    logic [CELL_W-1:0] csel;
    logic [SLOT_W-1:0] ssel;
  } beat_t;

  // Ports of the block; every input starts at a known value.
  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [CFG_W-1:0]     cfg_data_i    = '0;
  logic                 in_valid_i    = 1'b0;
  logic                 in_stall_o;
  logic [1:0]           command_i     = '0;
  logic [31:0]          pos_x_i       = '0;
  logic [31:0]          pos_y_i       = '0;
  logic [CELL_W-1:0]    cell_select_i = '0;
  logic [SLOT_W-1:0]    slot_select_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i   = 1'b0;
  logic [CELL_W-1:0]    cell_index_o;
  logic [CNT_W-1:0]     slot_o;
  logic [PART_W-1:0]    particle_index_o;
  logic [CNT_W-1:0]     cell_count_o;
  logic                 overflow_o;
  logic [CNT_W-1:0]     needed_capacity_o;

  particle_cell_list_binner DUT (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .command_i         (command_i),
    .pos_x_i           (pos_x_i),
    .pos_y_i           (pos_y_i),
    .cell_select_i     (cell_select_i),
    .slot_select_i     (slot_select_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .cell_index_o      (cell_index_o),
    .slot_o            (slot_o),
    .particle_index_o  (particle_index_o),
    .cell_count_o      (cell_count_o),
    .overflow_o        (overflow_o),
    .needed_capacity_o (needed_capacity_o)
  );

  always #5 clk_i = ~clk_i;

  // Beats waiting to be sent, and the results the binning table must report.
  beat_t beat_q[$];
  res_t  report_q[$];
  int    recent_cells[$];

  // Shadow copy of the geometry registers, mirrored on every write.
  logic [31:0]       inv_q = RST_INV_CELL_SIZE;
  logic [AXIS_W-1:0] cx_q  = RST_CELLS;
  logic [AXIS_W-1:0] cy_q  = RST_CELLS;
  logic [CNT_W-1:0]  spc_q = RST_SLOTS;

  // Shadow binning table.
  logic [CNT_W-1:0]  count_mem [MAX_CELLS];
  logic [PART_W-1:0] slot_mem  [MAX_CELLS*MAX_SLOTS];
  logic [PCNT_W-1:0] placed_q;
  logic              ovf_q;
  logic [CNT_W-1:0]  need_q;

  int    send_mode = 1;
  int    recv_mode = 1;
  int    send_gap  = 0;
  int    recv_hold = 0;
  bit    took;
  beat_t cur;
  res_t  got, want;
  int    errors  = 0;
  int    n_place = 0;
  int    n_read  = 0;
  int    n_clear = 0;
  int    n_ovf   = 0;
  int    n_skip  = 0;

  // Idle gap for one beat: none, a random gap each time, or only an occasional one.
  function automatic int draw_wait(int mode);
    case (mode)
      0:       return 0;
      1:       return $urandom_range(0, 16);
      default: return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 16) : 0;
    endcase
  endfunction

  // Grid extent along one axis: zero acts as one, anything past 64 as 64.
  function automatic logic [AXIS_W-1:0] grid_span(logic [AXIS_W-1:0] r);
    return (r == '0) ? AXIS_W'(1) : ((r > AXIS_W'(AXIS_MAX)) ? AXIS_W'(AXIS_MAX) : r);
  endfunction

  // Floor of pos * inv_cell_size on the full 64-bit product, clamped to the axis.
  function automatic int axis_bin(logic [31:0] pos, logic [AXIS_W-1:0] n);
    logic [63:0] p;
    p = ({32'd0, pos} * {32'd0, inv_q}) >> 32;
    if (p > 64'(n) - 64'd1) p = 64'(n) - 64'd1;
    return int'(p);
  endfunction

  function automatic int cell_of(logic [31:0] px, logic [31:0] py);
    int c;
    c = axis_bin(py, grid_span(cy_q)) * int'(grid_span(cx_q)) + axis_bin(px, grid_span(cx_q));
    return (c >= MAX_CELLS) ? MAX_CELLS - 1 : c;
  endfunction

  // Apply one command to the shadow table and return what the block must report.
  function automatic res_t bin_command(beat_t b);
    res_t r;
    int   cidx;
    int   off;
    int   cap;
    r   = '0;
    cap = (spc_q == '0) ? 1 : ((spc_q > CNT_W'(MAX_SLOTS)) ? MAX_SLOTS : int'(spc_q));
    case (b.cmd)
      CMD_CLEAR: begin
        foreach (count_mem[i]) count_mem[i] = '0;
        placed_q = '0;
        ovf_q    = 1'b0;
        need_q   = '0;
        n_clear++;
      end
      CMD_PLACE: begin
        if (!ovf_q && placed_q < MAX_PARTICLES) begin
          cidx             = cell_of(b.px, b.py);
          off              = int'(count_mem[cidx]);
          r.cell_index     = CELL_W'(cidx);
          r.particle_index = placed_q[PART_W-1:0];
          if (off < cap) begin
            slot_mem[cidx*MAX_SLOTS+off] = placed_q[PART_W-1:0];
            r.slot   = CNT_W'(off);
            placed_q = placed_q + 1'b1;
            n_place++;
          end else begin
            // Full cell: poison the slot, latch the capacity that would have fit.
            if (off < MAX_SLOTS) slot_mem[cidx*MAX_SLOTS+off] = '0;
            ovf_q  = 1'b1;
            need_q = CNT_W'(off + 1);
            n_ovf++;
          end
          if (off < 31) count_mem[cidx] = CNT_W'(off + 1);
          r.cell_count = count_mem[cidx];
        end else begin
          n_skip++;
        end
      end
      CMD_READ: begin
        r.cell_index = b.csel;
        r.slot       = CNT_W'(b.ssel);
        r.cell_count = count_mem[b.csel];
        if (CNT_W'(b.ssel) < count_mem[b.csel]) r.particle_index = slot_mem[{b.csel, b.ssel}];
        n_read++;
      end
      default: n_skip++;
    endcase
    r.overflow        = ovf_q;
    r.needed_capacity = need_q;
    return r;
  endfunction

  function automatic void check_field(string what, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      // Keep the log readable when the block is badly broken.
      if (errors <= 100) begin
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, what, exp_v, act_v);
      end
    end
  endfunction

  // Driver: predict each accepted beat, then present the next one after its gap.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      command_i     <= CMD_NOP;
      pos_x_i       <= '0;
      pos_y_i       <= '0;
      cell_select_i <= '0;
      slot_select_i <= '0;
      send_gap       = 0;
      foreach (count_mem[i]) count_mem[i] = '0;
      placed_q = '0;
      ovf_q    = 1'b0;
      need_q   = '0;
    end else begin
      took = in_valid_i && !in_stall_o;
      if (took) begin
        report_q = {report_q, bin_command(cur)};
      end
      // Hold the payload while stalled; otherwise idle out the gap or advance.
      if (!in_valid_i || took) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (beat_q.size() > 0) begin
          cur            = beat_q.pop_front();
          command_i     <= cur.cmd;
          pos_x_i       <= cur.px;
          pos_y_i       <= cur.py;
          cell_select_i <= cur.csel;
          slot_select_i <= cur.ssel;
          in_valid_i    <= 1'b1;
          send_gap       = draw_wait(send_mode);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result against the oldest prediction, then stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_hold    = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        got = {cell_index_o, slot_o, particle_index_o, cell_count_o, overflow_o,
               needed_capacity_o};
        if (report_q.size() == 0) begin
          errors++;
          $display("%0t ns: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = report_q.pop_front();
          check_field("cell_index", want.cell_index, got.cell_index);
          check_field("slot", want.slot, got.slot);
          check_field("particle_index", want.particle_index, got.particle_index);
          check_field("cell_count", want.cell_count, got.cell_count);
          check_field("overflow", want.overflow, got.overflow);
          check_field("needed_capacity", want.needed_capacity, got.needed_capacity);
        end
        recv_hold = draw_wait(recv_mode);
      end else if (recv_hold > 0) begin
        recv_hold--;
      end
      out_stall_i <= (recv_hold != 0);
    end
  end

  // Wait until every beat is sent and answered and any clearing sweep is over.
  task automatic wait_drained();
    forever begin
      do @(negedge clk_i);
      while (beat_q.size() != 0 || in_valid_i || report_q.size() != 0 || in_stall_o !== 1'b0);
      // Let a sweep that starts right after a clear result raise the stall first.
      repeat (8) @(negedge clk_i);
      if (in_stall_o === 1'b0 && report_q.size() == 0) break;
    end
  endtask

  task automatic write_reg(reg_e idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    case (idx)
      REG_INV_CELL_SIZE:  inv_q = val;
      REG_CELLS_X:        cx_q  = val[AXIS_W-1:0];
      REG_CELLS_Y:        cy_q  = val[AXIS_W-1:0];
      REG_SLOTS_PER_CELL: spc_q = val[CNT_W-1:0];
      default: ;
    endcase
  endtask

  // Write all four registers; junk above each narrow field must be dropped.
  task automatic set_geometry(logic [31:0] inv, logic [AXIS_W-1:0] gx,
                              logic [AXIS_W-1:0] gy, logic [CNT_W-1:0] spc);
    write_reg(REG_INV_CELL_SIZE, inv);
    write_reg(REG_CELLS_X, ($urandom() & 32'hFFFF_FF80) | 32'(gx));
    write_reg(REG_CELLS_Y, ($urandom() & 32'hFFFF_FF80) | 32'(gy));
    write_reg(REG_SLOTS_PER_CELL, ($urandom() & 32'hFFFF_FFE0) | 32'(spc));
    @(negedge clk_i);
  endtask

  task automatic push_beat(cmd_e c, logic [31:0] px, logic [31:0] py,
                           logic [CELL_W-1:0] cs, logic [SLOT_W-1:0] ss);
    beat_t b;
    b.cmd  = c;
    b.px   = px;
    b.py   = py;
    b.csel = cs;
    b.ssel = ss;
    beat_q = {beat_q, b};
    // Remember where places land so reads can aim at occupied cells.
    if (c == CMD_PLACE) begin
      recent_cells = {recent_cells, cell_of(px, py)};
      if (recent_cells.size() > 8) void'(recent_cells.pop_front());
    end
  endtask

  // Position spread over every magnitude, from zero up to the full 32-bit range.
  function automatic logic [31:0] rand_pos();
    return $urandom() >> $urandom_range(0, 31);
  endfunction

  initial begin
    int                n_rand;
    int                phase;
    int                nitems;
    int                pick;
    logic [31:0]       inv;
    logic [AXIS_W-1:0] gx, gy;
    logic [CNT_W-1:0]  spc;
    logic [CELL_W-1:0] cs;
    logic [SLOT_W-1:0] ss;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_drained();

    // Directed: unit scale on a 4x4 grid with two slots per cell.
    set_geometry(32'h0001_0000, AXIS_W'(4), AXIS_W'(4), CNT_W'(2));
    push_beat(CMD_PLACE, 32'h0, 32'h0, '0, '0);
    push_beat(CMD_PLACE, 32'h0000_FFFF, 32'h0000_FFFF, '1, '1);
    push_beat(CMD_PLACE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, '0);
    push_beat(CMD_PLACE, 32'h0003_8000, 32'h0001_0000, '0, '0);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd0);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd1);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd2);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd15);
    // Third place into cell 0 overflows it; the next place is dropped.
    push_beat(CMD_PLACE, 32'h0, 32'h0, '0, '0);
    push_beat(CMD_PLACE, 32'h0002_0000, 32'h0, '0, '0);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd2);
    push_beat(CMD_NOP, $urandom(), $urandom(), '1, '1);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd4095, 4'd15);
    push_beat(CMD_CLEAR, $urandom(), $urandom(), '1, '1);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd0);
    push_beat(CMD_PLACE, 32'h0, 32'h0, '0, '0);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd15, 4'd0);
    wait_drained();

    // Directed: zero scale bins everything to cell 0; a zero-sized grid and zero capacity act as one.
    set_geometry(32'h0, AXIS_W'(0), AXIS_W'(0), CNT_W'(0));
    push_beat(CMD_CLEAR, 32'h0, 32'h0, '0, '0);
    push_beat(CMD_PLACE, $urandom(), $urandom(), '0, '0);
    push_beat(CMD_PLACE, $urandom(), $urandom(), '0, '0);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd1);
    push_beat(CMD_READ, $urandom(), $urandom(), 12'd0, 4'd0);
    wait_drained();

    // Random phases: new geometry while idle, a clear, then a burst of beats.
    n_rand = 0;
    phase  = 0;
    while (n_rand < 1400) begin
      case ($urandom_range(0, 5))
        0:       inv = 32'h0001_0000;
        1:       inv = 32'h0010_0000;
        2:       inv = 32'h0000_1000;
        3:       inv = $urandom();
        4:       inv = 32'hFFFF_FFFF;
        default: inv = 32'h0;
      endcase
      pick = $urandom_range(0, 9);
      gx   = (pick < 6) ? AXIS_W'($urandom_range(1, 8)) : (pick == 6) ? AXIS_W'(64) :
             (pick == 7) ? AXIS_W'($urandom_range(9, 64)) : (pick == 8) ? AXIS_W'(0) :
             AXIS_W'($urandom_range(65, 127));
      pick = $urandom_range(0, 9);
      gy   = (pick < 6) ? AXIS_W'($urandom_range(1, 8)) : (pick == 6) ? AXIS_W'(64) :
             (pick == 7) ? AXIS_W'($urandom_range(9, 64)) : (pick == 8) ? AXIS_W'(0) :
             AXIS_W'($urandom_range(65, 127));
      spc  = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 31)) :
             CNT_W'($urandom_range(1, 6));
      // Open with a single-cell grid at full capacity so a cell reaches 17,
      // then the widest grid with the largest scale.
      if (phase == 0) begin
        gx  = AXIS_W'(0);
        gy  = AXIS_W'(0);
        spc = CNT_W'(31);
      end else if (phase == 1) begin
        inv = 32'hFFFF_FFFF;
        gx  = AXIS_W'(127);
        gy  = AXIS_W'(127);
        spc = CNT_W'(0);
      end
      send_mode = $urandom_range(0, 2);
      recv_mode = $urandom_range(0, 2);
      set_geometry(inv, gx, gy, spc);
      recent_cells.delete();
      push_beat(CMD_CLEAR, $urandom(), $urandom(), 12'($urandom()), 4'($urandom()));
      nitems = $urandom_range(20, 70);
      repeat (nitems) begin
        pick = $urandom_range(0, 99);
        if (pick < 62) begin
          push_beat(CMD_PLACE, rand_pos(), rand_pos(), 12'($urandom()), 4'($urandom()));
        end else if (pick < 94) begin
          cs = (recent_cells.size() > 0 && $urandom_range(0, 2) != 0) ?
               CELL_W'(recent_cells[$urandom_range(0, recent_cells.size() - 1)]) :
               CELL_W'($urandom());
          ss = ($urandom_range(0, 1) != 0) ? SLOT_W'($urandom_range(0, 3)) : SLOT_W'($urandom());
          push_beat(CMD_READ, $urandom(), $urandom(), cs, ss);
        end else if (pick < 96) begin
          push_beat(CMD_CLEAR, $urandom(), $urandom(), 12'($urandom()), 4'($urandom()));
        end else begin
          push_beat(CMD_NOP, $urandom(), $urandom(), 12'($urandom()), 4'($urandom()));
        end
      end
      n_rand += nitems + 1;
      phase++;
      // Hold off the next phase until every result is back.
      wait_drained();
    end

    // Watch a while longer for stray result beats.
    repeat (32) @(posedge clk_i);
    $display("Covered %0d placements, %0d reads, %0d clears, %0d overflow events",
             n_place, n_read, n_clear, n_ovf);
    $display("%0d beats left the table untouched, over %0d random geometry phases",
             n_skip, phase);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #20ms;
    $display("== FAIL ==");
    $finish;
  end

endmodule
